// ----- hw/rtl/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants
// Register map codes, configuration bundle and the item formats that move
// between the window cells, the result lanes and the top level.
// ----------------------------------------------------------------------------
package spr_pkg;

  // bytes held by one 64-bit text register
  localparam int unsigned CFG_BYTES = 8;

  // apb address width and the bit that starts the register index
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned IDX_LSB = 3;

  // register index, byte address = 8 * index
  typedef enum logic [1:0] {
    REG_PATTERN_BYTES      = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT_BYTES  = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } reg_idx_e;

  // configuration register contents
  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_length;
  } cfg_t;

  // per-cell window control
  typedef struct packed {
    logic shift;     // full window without a match: take neighbour's byte
    logic append;    // incoming byte lands in this cell
    logic in_range;  // cell lies inside the active pattern length
  } win_ctl_t;

  // one result item as held in a lane
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } lane_t;

endpackage

// ----- hw/rtl/spr_cfg.sv -----
// ----------------------------------------------------------------------------
// spr_cfg: configuration registers
// APB-style register file for pattern and replacement text and lengths.
// Signals a pulse when the pattern length is written.
// ----------------------------------------------------------------------------
module spr_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spr_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  output spr_pkg::cfg_t              cfg_o,
  output logic                       plen_wr_o
);

  spr_pkg::cfg_t    cfg_q, cfg_d;
  spr_pkg::reg_idx_e idx;
  logic             wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = spr_pkg::reg_idx_e'(paddr[spr_pkg::ADDR_W-1:spr_pkg::IDX_LSB]);

  // write decode
  always_comb begin
    cfg_d     = cfg_q;
    plen_wr_o = 1'b0;
    if (wr) begin
      unique case (idx)
        spr_pkg::REG_PATTERN_BYTES:      cfg_d.pattern_bytes = pwdata;
        spr_pkg::REG_PATTERN_LENGTH: begin
          cfg_d.pattern_length = pwdata[3:0];
          plen_wr_o            = 1'b1;
        end
        spr_pkg::REG_REPLACEMENT_BYTES:  cfg_d.replacement_bytes = pwdata;
        spr_pkg::REG_REPLACEMENT_LENGTH: cfg_d.replacement_length = pwdata[3:0];
        default: ;
      endcase
    end
  end

  // read decode
  always_comb begin
    unique case (idx)
      spr_pkg::REG_PATTERN_BYTES:      prdata = cfg_q.pattern_bytes;
      spr_pkg::REG_PATTERN_LENGTH:     prdata = 64'(cfg_q.pattern_length);
      spr_pkg::REG_REPLACEMENT_BYTES:  prdata = cfg_q.replacement_bytes;
      spr_pkg::REG_REPLACEMENT_LENGTH: prdata = 64'(cfg_q.replacement_length);
      default:                         prdata = '0;
    endcase
  end

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_bytes      <= '0;
      cfg_q.pattern_length     <= 4'd1;
      cfg_q.replacement_bytes  <= '0;
      cfg_q.replacement_length <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/spr_win_cell.sv -----
// ----------------------------------------------------------------------------
// spr_win_cell: one window position
// Holds one pending byte, compares it against its pattern byte and extends
// the match chain; shifts in its neighbour's byte when the window slides.
// ----------------------------------------------------------------------------
module spr_win_cell (
  input  logic              clk_i,
  input  spr_pkg::win_ctl_t ctl_i,
  input  logic [7:0]        in_byte_i,
  input  logic [7:0]        pat_byte_i,
  input  logic [7:0]        next_byte_i,
  input  logic              match_i,
  output logic [7:0]        byte_o,
  output logic              match_o
);

  logic [7:0] win_q, win_d;

  // window content as it stands once the incoming byte is in place
  assign byte_o  = ctl_i.append ? in_byte_i : win_q;

  // match chain, positions past the pattern length always agree
  assign match_o = match_i & (~ctl_i.in_range | (byte_o == pat_byte_i));

  // slide or append
  always_comb begin
    if (ctl_i.shift) begin
      win_d = next_byte_i;
    end else if (ctl_i.append) begin
      win_d = in_byte_i;
    end else begin
      win_d = win_q;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

// ----- hw/rtl/spr_out_cell.sv -----
// ----------------------------------------------------------------------------
// spr_out_cell: one result lane
// Holds one pending result item; moves down one lane whenever the head item
// is taken, or loads a freshly produced item.
// ----------------------------------------------------------------------------
module spr_out_cell (
  input  logic           clk_i,
  input  logic           pop_i,
  input  logic           load_i,
  input  spr_pkg::lane_t load_data_i,
  input  spr_pkg::lane_t next_i,
  output spr_pkg::lane_t lane_o
);

  spr_pkg::lane_t lane_q, lane_d;

  // new items always land behind what remains after the pop
  always_comb begin
    if (load_i) begin
      lane_d = load_data_i;
    end else if (pop_i) begin
      lane_d = next_i;
    end else begin
      lane_d = lane_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;

endmodule

// ----- hw/rtl/stream_pattern_replace_core.sv -----
// ----------------------------------------------------------------------------
// stream_pattern_replace_core: streaming find and replace
// Rewrites a byte string, replacing every leftmost non-overlapping
// occurrence of the pattern by the replacement text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one byte per item, the
//   final byte flagged by in_last_i. Output channel (out_valid_o /
//   out_stall_i) gives one byte per item; out_last_o marks the end of the
//   rewritten string, and byte_valid_o = 0 marks a bare end marker after a
//   final match with an empty replacement.
//   A row of MAX_PATTERN window cells compares the pending bytes against the
//   pattern in the cycle the byte arrives. Results go into a row of
//   MAX_OUT + 1 lanes that shift towards the output register.
//   Results are registered in the lanes. Throughput: one item per cycle
//   while each item yields at most one result and the receiver does not
//   stall; an item that yields more results holds the input until the
//   single output port has drained the lanes down to one result.
//   in_stall_o is high while two or more results wait in the lanes, so an
//   item is still taken while one result waits on a stalled receiver.
//   Reset empties the window and the lanes and loads pattern length 1, all
//   other registers zero. Configure over APB only while the block is idle;
//   writing the pattern length discards any pending window.
// ----------------------------------------------------------------------------
module stream_pattern_replace_core #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_REPLACE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spr_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 in_byte_i,
  input  logic                       in_last_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       byte_valid_o,
  output logic                       out_last_o
);

  localparam int unsigned CW      = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RW      = $clog2(MAX_REPLACE + 1);
  localparam int unsigned MAX_OUT = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
  localparam int unsigned OW      = $clog2(MAX_OUT + 1);
  localparam int unsigned NL      = MAX_OUT + 1;
  localparam int unsigned LW      = $clog2(NL + 1);

  spr_pkg::cfg_t  cfg;
  logic           plen_wr;

  logic [4:0]     plen_raw, plen_sat, rlen_sat;
  logic [CW-1:0]  plen;
  logic [RW-1:0]  rlen;

  logic [CW-1:0]  cnt_q, cnt_d, cnt_eff, new_cnt;
  logic           accept, full, hit, pop, marker, base;
  logic [OW-1:0]  n_data, n_emit;

  logic [7:0]     pw [MAX_PATTERN+1];
  logic           chain [MAX_PATTERN+1];

  spr_pkg::lane_t src   [MAX_OUT];
  spr_pkg::lane_t lanes [NL];
  logic [LW-1:0]  lane_cnt_q, lane_cnt_d;

  // configuration registers
  spr_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .plen_wr_o (plen_wr)
  );

  // effective lengths: zero pattern length reads as one, both saturate
  assign plen_raw = {1'b0, cfg.pattern_length};
  always_comb begin
    plen_sat = (plen_raw == 5'd0) ? 5'd1 : plen_raw;
    if (plen_sat > 5'(MAX_PATTERN)) begin
      plen_sat = 5'(MAX_PATTERN);
    end
    rlen_sat = {1'b0, cfg.replacement_length};
    if (rlen_sat > 5'(MAX_REPLACE)) begin
      rlen_sat = 5'(MAX_REPLACE);
    end
  end
  assign plen = CW'(plen_sat);
  assign rlen = RW'(rlen_sat);

  // handshakes
  assign in_stall_o  = lane_cnt_q > LW'(1);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = lane_cnt_q != '0;
  assign pop         = out_valid_o & ~out_stall_i;

  // window fill after the incoming byte
  assign cnt_eff = (cnt_q >= plen) ? '0 : cnt_q;
  assign new_cnt = cnt_eff + 1'b1;
  assign full    = new_cnt == plen;

  // row of window cells
  assign chain[0]        = 1'b1;
  assign pw[MAX_PATTERN] = 8'h00;
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_win
    spr_pkg::win_ctl_t ctl;
    logic [7:0]        pat_byte;

    if (i < spr_pkg::CFG_BYTES) begin : g_pat
      assign pat_byte = cfg.pattern_bytes[8*i +: 8];
    end else begin : g_pat_zero
      assign pat_byte = 8'h00;
    end

    assign ctl.shift    = accept & full & ~hit;
    assign ctl.append   = accept & (cnt_eff == CW'(i));
    assign ctl.in_range = CW'(i) < plen;

    spr_win_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .in_byte_i   (in_byte_i),
      .pat_byte_i  (pat_byte),
      .next_byte_i (pw[i+1]),
      .match_i     (chain[i]),
      .byte_o      (pw[i]),
      .match_o     (chain[i+1])
    );
  end

  assign hit = full & chain[MAX_PATTERN];

  // window count
  always_comb begin
    cnt_d = cnt_q;
    if (plen_wr) begin
      cnt_d = '0;
    end else if (accept) begin
      if (in_last_i || hit) begin
        cnt_d = '0;
      end else if (full) begin
        cnt_d = plen - 1'b1;
      end else begin
        cnt_d = new_cnt;
      end
    end
  end

  // number of results for this item
  always_comb begin
    if (hit) begin
      n_data = OW'(rlen);
    end else if (in_last_i) begin
      n_data = OW'(new_cnt);
    end else if (full) begin
      n_data = OW'(1);
    end else begin
      n_data = '0;
    end
  end
  assign marker = in_last_i & (n_data == '0);
  assign n_emit = marker ? OW'(1) : n_data;

  // result items: replacement text, the window front to back, or a bare end marker
  for (genvar j = 0; j < MAX_OUT; j++) begin : g_src
    logic [7:0] rep_byte, win_byte;

    if (j < MAX_REPLACE && j < spr_pkg::CFG_BYTES) begin : g_rep
      assign rep_byte = cfg.replacement_bytes[8*j +: 8];
    end else begin : g_rep_zero
      assign rep_byte = 8'h00;
    end

    if (j < MAX_PATTERN) begin : g_wb
      assign win_byte = pw[j];
    end else begin : g_wb_zero
      assign win_byte = 8'h00;
    end

    assign src[j].data       = marker ? 8'h00 : (hit ? rep_byte : win_byte);
    assign src[j].byte_valid = ~marker;
    assign src[j].last       = in_last_i & ((OW'(j) + 1'b1) == n_emit);
  end

  // load offset: one result may still sit at the head
  assign base = (lane_cnt_q == LW'(1)) & ~pop;

  // row of result lanes
  for (genvar k = 0; k < NL; k++) begin : g_lane
    spr_pkg::lane_t src_a, src_b, nxt, ld_data;
    logic           ld_a, ld_b, ld;

    if (k < MAX_OUT) begin : g_a
      assign src_a = src[k];
      assign ld_a  = OW'(k) < n_emit;
    end else begin : g_a_none
      assign src_a = '0;
      assign ld_a  = 1'b0;
    end

    if (k >= 1) begin : g_b
      assign src_b = src[k-1];
      assign ld_b  = OW'(k - 1) < n_emit;
    end else begin : g_b_none
      assign src_b = '0;
      assign ld_b  = 1'b0;
    end

    if (k < NL - 1) begin : g_nxt
      assign nxt = lanes[k+1];
    end else begin : g_nxt_none
      assign nxt = '0;
    end

    assign ld_data = base ? src_b : src_a;
    assign ld      = accept & (base ? ld_b : ld_a);

    spr_out_cell u_lane (
      .clk_i       (clk_i),
      .pop_i       (pop),
      .load_i      (ld),
      .load_data_i (ld_data),
      .next_i      (nxt),
      .lane_o      (lanes[k])
    );
  end

  // lane occupancy
  always_comb begin
    lane_cnt_d = lane_cnt_q;
    if (pop) begin
      lane_cnt_d = lane_cnt_d - 1'b1;
    end
    if (accept) begin
      lane_cnt_d = lane_cnt_d + LW'(n_emit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      lane_cnt_q <= '0;
    end else begin
      cnt_q      <= cnt_d;
      lane_cnt_q <= lane_cnt_d;
    end
  end

  // head lane drives the output
  assign out_byte_o   = lanes[0].data;
  assign byte_valid_o = lanes[0].byte_valid;
  assign out_last_o   = lanes[0].last;

endmodule
